### design/rational_arithmetic_unit_defines.svh
// assertion macros shared by the checker
// no dependencies
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
// implication checked every clock outside reset
`define RAU_ASSERT_IMPL(label, rst, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define RAU_ASSERT_NEXT(label, rst, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
        else $error(msg);
`endif

### design/rau_pkg.sv
// package: operation and status codes, controller states, command/status structs
// no dependencies
package rau_pkg;
    localparam int OperandBits = 32;

    localparam logic [2:0] MODE_ADD = 3'd0;
    localparam logic [2:0] MODE_SUB = 3'd1;
    localparam logic [2:0] MODE_MUL = 3'd2;
    localparam logic [2:0] MODE_DIV = 3'd3;
    localparam logic [2:0] MODE_CMP = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ZDEN   = 2'd1;
    localparam logic [1:0] ST_DIVZ   = 2'd2;

    localparam logic [1:0] ORD_LESS  = 2'd0;
    localparam logic [1:0] ORD_EQ    = 2'd1;
    localparam logic [1:0] ORD_GREAT = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_MUL1, S_MUL2, S_GCD, S_DIV1, S_DIV2, S_FIN, S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic gcd_start;
        logic div1_start;
        logic div2_start;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic early;
        logic gcd_done;
        logic div_done;
    } stat_t;
endpackage

### design/rau_if.sv
// valid/ready channel interfaces for operands and results
// depends on nothing
interface rau_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic signed [31:0] a_num;
    logic [30:0] a_den;
    logic signed [31:0] b_num;
    logic [30:0] b_den;
    modport source (output valid, mode, a_num, a_den, b_num, b_den, input ready);
    modport sink (input valid, mode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
    logic        valid;
    logic        ready;
    logic signed [63:0] res_num;
    logic [62:0] res_den;
    logic [1:0]  order;
    logic [1:0]  status;
    modport source (output valid, res_num, res_den, order, status, input ready);
    modport sink (input valid, res_num, res_den, order, status, output ready);
endinterface

### design/rau_ctrl.sv
// controller state machine sequencing load, multiplies, gcd and divides
// depends on rau_pkg
module rau_ctrl
    import rau_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.mul1 = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul2 = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                if (stat.early)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.gcd_start = 1'b1;
                    state_next = S_GCD;
                end
            end
            S_GCD:
                if (stat.gcd_done)
                begin
                    cmd.div1_start = 1'b1;
                    state_next = S_DIV1;
                end
            S_DIV1:
                if (stat.div_done)
                begin
                    cmd.div2_start = 1'b1;
                    state_next = S_DIV2;
                end
            S_DIV2:
                if (stat.div_done)
                    state_next = S_FIN;
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

### design/rau_dp.sv
// datapath: operand registers, shared multiplier, binary gcd, restoring divider
// depends on rau_pkg
module rau_dp
    import rau_pkg::*;
#(
    parameter int OPERAND_BITS = OperandBits
)
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    output stat_t stat,
    input  logic [2:0]  mode,
    input  logic signed [31:0] a_num,
    input  logic [30:0] a_den,
    input  logic signed [31:0] b_num,
    input  logic [30:0] b_den,
    output logic signed [63:0] res_num,
    output logic [62:0] res_den,
    output logic [1:0]  order,
    output logic [1:0]  status
);
    localparam int NB = OPERAND_BITS;
    localparam int DB = OPERAND_BITS - 1;

    logic [2:0]  mode_reg;
    logic        an_neg_reg, bn_neg_reg;
    logic [NB-1:0] an_mag_reg, bn_mag_reg;
    logic [DB-1:0] ad_reg, bd_reg;
    logic [63:0] p1_reg, p2_reg;
    logic [63:0] m_reg, d_reg;
    logic        neg_reg;
    logic [63:0] gx_reg, gy_reg;
    logic [6:0]  gk_reg;
    logic        gbusy_reg;
    logic [63:0] q_reg, r_reg, dvs_reg;
    logic [6:0]  dcnt_reg;
    logic        dbusy_reg;
    logic [63:0] q1_reg;
    logic [63:0] g_reg;
    logic signed [63:0] rn_reg;
    logic [62:0] rd_reg;
    logic [1:0]  ord_reg, st_reg;

    logic signed [NB-1:0] an_s, bn_s;
    logic [NB-1:0] an_m, bn_m;
    logic [63:0] mul_x, mul_y, mul_p;
    logic addsub;
    logic zden, divz;
    logic [64:0] rtrial;
    logic [63:0] gdiff;
    logic [63:0] sa_p, sb_p, lcm_p;

    assign an_s = a_num[NB-1:0];
    assign bn_s = b_num[NB-1:0];
    assign an_m = an_s[NB-1] ? NB'(-an_s) : NB'(an_s);
    assign bn_m = bn_s[NB-1] ? NB'(-bn_s) : NB'(bn_s);
    assign addsub = (mode_reg == MODE_ADD) || (mode_reg == MODE_SUB);
    assign zden = (ad_reg == '0) || (bd_reg == '0);
    assign divz = (mode_reg == MODE_DIV) && (bn_mag_reg == '0);

    // product pair: cross products (div/cmp), num and den products (mul); add/sub products unused
    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        if (cmd.mul1)
        begin
            mul_x = 64'(an_mag_reg);
            mul_y = (mode_reg == MODE_MUL) ? 64'(bn_mag_reg) : 64'(bd_reg);
        end
        else
        begin
            mul_x = 64'(ad_reg);
            mul_y = (mode_reg == MODE_MUL) ? 64'(bd_reg)
                  : (mode_reg == MODE_DIV) ? 64'(bn_mag_reg)
                  : (addsub ? 64'(bd_reg) : 64'(bn_mag_reg));
        end
    end
    assign mul_p = mul_x[31:0] * mul_y[31:0];

    // add/sub scaling: a by bd/g, b by ad/g, lcm as (ad/g)*bd
    assign sa_p = 32'(an_mag_reg) * q_reg[31:0];
    assign sb_p = 32'(bn_mag_reg) * q1_reg[31:0];
    assign lcm_p = q1_reg[31:0] * 32'(bd_reg);

    // early finish for errors, compare and unused modes
    assign stat.early = zden || divz || (mode_reg > MODE_CMP)
                        || (mode_reg == MODE_CMP);
    assign stat.gcd_done = !gbusy_reg;
    assign stat.div_done = !dbusy_reg;

    assign rtrial = {r_reg, q_reg[63]} - {1'b0, dvs_reg};
    assign gdiff = gx_reg - gy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gbusy_reg <= 1'b0;
            dbusy_reg <= 1'b0;
        end
        else
        begin
            if (cmd.gcd_start)
                gbusy_reg <= 1'b1;
            else if (gbusy_reg && gx_reg == '0)
                gbusy_reg <= 1'b0;
            if (cmd.div1_start || cmd.div2_start)
                dbusy_reg <= 1'b1;
            else if (dbusy_reg && dcnt_reg == 7'd63)
                dbusy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg   <= mode;
            an_neg_reg <= an_s[NB-1];
            bn_neg_reg <= bn_s[NB-1];
            an_mag_reg <= an_m;
            bn_mag_reg <= bn_m;
            ad_reg     <= a_den[DB-1:0];
            bd_reg     <= b_den[DB-1:0];
        end
        if (cmd.mul1)
            p1_reg <= mul_p;
        if (cmd.mul2)
        begin
            p2_reg <= mul_p;
            neg_reg <= an_neg_reg ^ bn_neg_reg;
            m_reg <= p1_reg;
            d_reg <= mul_p;
        end
        // gcd start: add/sub use the denominators, others the result pair
        if (cmd.gcd_start)
        begin
            gk_reg <= '0;
            if (addsub)
            begin
                gx_reg <= 64'(ad_reg);
                gy_reg <= 64'(bd_reg);
            end
            else
            begin
                gx_reg <= p1_reg;
                gy_reg <= d_reg;
            end
        end
        else if (gbusy_reg && gx_reg != '0)
        begin
            // binary gcd: strip common twos, then halve or subtract and halve
            priority if (!gx_reg[0] && !gy_reg[0])
            begin
                gx_reg <= gx_reg >> 1;
                gy_reg <= gy_reg >> 1;
                gk_reg <= gk_reg + 7'd1;
            end
            else if (!gx_reg[0])
                gx_reg <= gx_reg >> 1;
            else if (!gy_reg[0])
                gy_reg <= gy_reg >> 1;
            else if (gx_reg >= gy_reg)
                gx_reg <= gdiff >> 1;
            else
                gy_reg <= (gy_reg - gx_reg) >> 1;
        end
        if (gbusy_reg && gx_reg == '0)
            g_reg <= gy_reg << gk_reg;
        // restoring divider, one quotient bit a cycle
        if (cmd.div1_start || cmd.div2_start)
        begin
            q_reg <= cmd.div1_start ? (addsub ? 64'(ad_reg) : m_reg)
                                    : (addsub ? 64'(bd_reg) : d_reg);
            dvs_reg <= g_reg;
            r_reg <= '0;
            dcnt_reg <= '0;
            if (cmd.div2_start)
                q1_reg <= q_reg;
        end
        else if (dbusy_reg)
        begin
            dcnt_reg <= dcnt_reg + 7'd1;
            if (!rtrial[64])
            begin
                r_reg <= rtrial[63:0];
                q_reg <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_reg <= {r_reg[62:0], q_reg[63]};
                q_reg <= {q_reg[62:0], 1'b0};
            end
        end
        if (cmd.finish)
        begin
            rn_reg <= '0;
            rd_reg <= '0;
            ord_reg <= ORD_LESS;
            st_reg <= ST_OK;
            priority if (zden)
                st_reg <= ST_ZDEN;
            else if (divz)
                st_reg <= ST_DIVZ;
            else if (mode_reg == MODE_CMP)
            begin
                // compare signed cross products
                priority if ($signed({an_neg_reg, p1_reg}) == $signed({bn_neg_reg, p2_reg})
                             || (p1_reg == '0 && p2_reg == '0))
                    ord_reg <= ORD_EQ;
                else if ((an_neg_reg && !bn_neg_reg)
                         || (an_neg_reg && bn_neg_reg && p1_reg > p2_reg)
                         || (!an_neg_reg && !bn_neg_reg && p1_reg < p2_reg))
                    ord_reg <= ORD_LESS;
                else
                    ord_reg <= ORD_GREAT;
            end
            else if (addsub)
            begin
                // q holds bd/g, q1 holds ad/g
                rd_reg <= lcm_p[62:0];
                rn_reg <= (an_neg_reg ? -$signed(sa_p) : $signed(sa_p))
                        + (((mode_reg == MODE_SUB) ^ bn_neg_reg)
                           ? -$signed(sb_p) : $signed(sb_p));
            end
            else if (mode_reg == MODE_MUL || mode_reg == MODE_DIV)
            begin
                rn_reg <= neg_reg ? -$signed(q1_reg) : $signed(q1_reg);
                rd_reg <= q_reg[62:0];
            end
        end
    end

    assign res_num = rn_reg;
    assign res_den = rd_reg;
    assign order = ord_reg;
    assign status = st_reg;
endmodule

### design/rational_arithmetic_unit.sv
// rational arithmetic unit: two fractions in, one fraction with status out
// channels: in (mode, a_num, a_den, b_num, b_den), out (res_num, res_den, order, status)
// valid/ready on both; an item is taken when valid and ready are high together
// one item at a time: input ready only while the controller idles
// compare, errors and unused modes: after load and both multiply states the
// controller goes straight to finish and presents the result, with no gcd or divide
// add/sub/mul/div: after load and both multiply states come the binary gcd,
// then two restoring divides of 64 quotient bits on the shared divider, then
// the finish state; after the result is taken the controller returns to idle
// before the next item is taken
// multiply/divide reduce by the gcd, add/sub scale by the lcm unreduced
// result is held in output registers until taken; a stalled receiver
// keeps the block busy and input ready low
// reset (rst_n low, asynchronous) returns the controller to idle,
// no result pending
// depends on rau_pkg, rau_if, rau_ctrl, rau_dp
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int OPERAND_BITS = OperandBits
)
(
    input logic clk,
    input logic rst_n,
    rau_in_if.sink    in,
    rau_out_if.source out
);
    cmd_t  cmd;
    stat_t stat;

    rau_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in.valid), .in_ready(in.ready),
        .out_valid(out.valid), .out_ready(out.ready),
        .stat(stat), .cmd(cmd)
    );

    rau_dp #(.OPERAND_BITS(OPERAND_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .mode(in.mode), .a_num(in.a_num), .a_den(in.a_den),
        .b_num(in.b_num), .b_den(in.b_den),
        .res_num(out.res_num), .res_den(out.res_den),
        .order(out.order), .status(out.status)
    );
endmodule

### design/rau_checker.sv
// port-level checker for the rational arithmetic unit, bound to the top
// depends on rau_pkg and rational_arithmetic_unit_defines.svh
`include "rational_arithmetic_unit_defines.svh"
module rau_checker
    import rau_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [1:0] status,
    input logic [1:0] order
);
    `RAU_ASSERT_IMPL(a_excl, rst_n, out_valid, !in_ready, "input ready while result pending")
    `RAU_ASSERT_NEXT(a_hold, rst_n, out_valid && !out_ready, out_valid, "result dropped")
    `RAU_ASSERT_NEXT(a_busy, rst_n, in_valid && in_ready, !in_ready, "item taken while busy")
    `RAU_ASSERT_IMPL(a_code, rst_n, out_valid, status <= ST_DIVZ && order <= ORD_GREAT, "bad code")
endmodule

bind rational_arithmetic_unit rau_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in.valid), .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready),
    .status(out.status), .order(out.order)
);

### verif/tb_rational_arithmetic_unit.sv
// testbench for rational_arithmetic_unit: directed and random fractions, all modes
// self-checking against a behavioral fraction calculator; uses rau_pkg and rau_if
`timescale 1ns / 1ps
module tb_rational_arithmetic_unit
    import rau_pkg::*;
();

    typedef struct {
        logic signed [63:0] num;
        logic [62:0]        den;
        logic [1:0]         ord;
        logic [1:0]         st;
    } frac_res_t;

    logic clk;
    logic rst_n;
    rau_in_if  in_ch();
    rau_out_if out_ch();

    rational_arithmetic_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .in(in_ch.sink),
        .out(out_ch.source)
    );

    frac_res_t pending_results[$];
    int        mismatches;
    int        send_idle_pct;
    int        recv_stall_pct;
    longint    cycle_count;
    localparam longint CycleLimit = 2000000;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic logic [63:0] mag64(logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic frac_res_t calc_fraction(logic [2:0] mode, logic signed [31:0] an32,
                                                logic [30:0] ad31, logic signed [31:0] bn32,
                                                logic [30:0] bd31);
        frac_res_t r;
        logic signed [63:0] an;
        logic signed [63:0] bn;
        logic signed [63:0] bs;
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic [63:0] ad;
        logic [63:0] bd;
        logic [63:0] g;
        logic [63:0] l;
        logic [63:0] m;
        logic [63:0] d;
        logic        neg;
        an = an32;
        bn = bn32;
        ad = ad31;
        bd = bd31;
        r.num = 0;
        r.den = 0;
        r.ord = ORD_LESS;
        r.st = ST_OK;
        neg = (an < 0) != (bn < 0);
        if (ad == 0 || bd == 0)
            r.st = ST_ZDEN;
        else if (mode == MODE_ADD || mode == MODE_SUB)
        begin
            g = gcd64(ad, bd);
            l = (ad / g) * bd;
            bs = (mode == MODE_SUB) ? -bn : bn;
            r.num = an * $signed(l / ad) + bs * $signed(l / bd);
            r.den = l[62:0];
        end
        else if (mode == MODE_MUL)
        begin
            m = mag64(an) * mag64(bn);
            d = ad * bd;
            g = gcd64(m, d);
            r.num = neg ? -$signed(m / g) : $signed(m / g);
            r.den = 63'(d / g);
        end
        else if (mode == MODE_DIV)
        begin
            if (bn == 0)
                r.st = ST_DIVZ;
            else
            begin
                m = mag64(an) * bd;
                d = ad * mag64(bn);
                g = gcd64(m, d);
                r.num = neg ? -$signed(m / g) : $signed(m / g);
                r.den = 63'(d / g);
            end
        end
        else if (mode == MODE_CMP)
        begin
            x = an * $signed(bd);
            y = bn * $signed(ad);
            r.ord = (x < y) ? ORD_LESS : ((x == y) ? ORD_EQ : ORD_GREAT);
        end
        return r;
    endfunction

    task automatic send_fraction_op(logic [2:0] mode, logic [31:0] an, logic [30:0] ad,
                                    logic [31:0] bn, logic [30:0] bd);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        in_ch.valid = 1'b1;
        in_ch.mode = mode;
        in_ch.a_num = an;
        in_ch.a_den = ad;
        in_ch.b_num = bn;
        in_ch.b_den = bd;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pending_results.push_back(calc_fraction(mode, an, ad, bn, bd));
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    // receiver stall and result check
    always @(negedge clk)
        out_ch.ready = rst_n && ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        frac_res_t e;
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item num=%0d", out_ch.res_num);
            end
            else
            begin
                e = pending_results.pop_front();
                if (out_ch.res_num !== e.num || out_ch.res_den !== e.den
                    || out_ch.order !== e.ord || out_ch.status !== e.st)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d/%0d ord %0d st %0d, got %0d/%0d ord %0d st %0d",
                                 e.num, e.den, e.ord, e.st, out_ch.res_num, out_ch.res_den,
                                 out_ch.order, out_ch.status);
                end
            end
        end
    end

    function automatic logic [31:0] rand_num();
        case ($urandom_range(3))
            0: return $urandom_range(20) - 10;
            1: return $urandom_range(2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] rand_den();
        case ($urandom_range(9))
            0: return 31'd0;
            1, 2: return 31'($urandom_range(12, 1));
            3, 4: return 31'($urandom_range(5000, 1));
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic drain_results();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic test_directed();
        logic [2:0] m;
        for (int i = 0; i <= 4; i++)
        begin
            m = 3'(i);
            send_fraction_op(m, 32'h7fffffff, 31'h7fffffff, 32'h80000000, 31'd1);
            send_fraction_op(m, 32'h80000000, 31'd1, 32'h80000000, 31'h7fffffff);
            send_fraction_op(m, 32'd3, 31'd4, 32'd3, 31'd4);
        end
        send_fraction_op(MODE_ADD, 32'd1, 31'd0, 32'd1, 31'd2);
        send_fraction_op(MODE_MUL, 32'd1, 31'd3, 32'd1, 31'd0);
        send_fraction_op(MODE_DIV, 32'd5, 31'd3, 32'd0, 31'd7);
        send_fraction_op(MODE_MUL, 32'd0, 31'd9, -32'sd7, 31'd5);
        send_fraction_op(MODE_DIV, 32'd2, 31'd3, -32'sd4, 31'd9);
        send_fraction_op(MODE_SUB, 32'd1, 31'd2, 32'd2, 31'd4);
        send_fraction_op(MODE_CMP, -32'sd1, 31'd2, 32'd1, 31'd3);
        send_fraction_op(3'd5, 32'd1, 31'd2, 32'd1, 31'd2);
        send_fraction_op(3'd7, 32'hffffffff, 31'h7fffffff, 32'd1, 31'd1);
        drain_results();
    endtask

    task automatic test_random(int count);
        logic [2:0] m;
        for (int i = 0; i < count; i++)
        begin
            m = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
            send_fraction_op(m, rand_num(), rand_den(), rand_num(), rand_den());
        end
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.mode = MODE_ADD;
        in_ch.a_num = '0;
        in_ch.a_den = '0;
        in_ch.b_num = '0;
        in_ch.b_den = '0;
        out_ch.ready = 1'b0;
        mismatches = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(250);
        send_idle_pct = 65;
        test_random(220);
        send_idle_pct = 0;
        recv_stall_pct = 65;
        test_random(220);
        send_idle_pct = 7;
        recv_stall_pct = 7;
        test_random(210);
        drain_results();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
